// ===== rtl/qoi_enc_pkg.sv =====
package qoi_enc_pkg;

  localparam int PIXEL_W     = 32;
  localparam int INDEX_DEPTH = 64;
  localparam int HASH_W      = 6;

  // chunk tags of the format
  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hc0;
  localparam logic [7:0] OP_RGB   = 8'hfe;
  localparam logic [7:0] OP_RGBA  = 8'hff;

  localparam logic [5:0] RUN_MAX = 6'd62;

  // red sits in the lowest byte, as on the input stream
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  localparam pixel_t PREV_RESET = 32'hff00_0000;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_INDEX,
    KIND_DIFF,
    KIND_LUMA,
    KIND_RGB,
    KIND_RGBA
  } kind_t;

  // one classified pixel: optional run flush, then at most one chunk
  typedef struct packed {
    logic       has_run;
    logic [5:0] run_m1;
    kind_t      kind;
    logic [7:0] op0;
    logic [7:0] op1;
    pixel_t     px;
    logic       last;
  } chunk_cmd_t;

  function automatic logic [HASH_W-1:0] color_hash(pixel_t p);
    logic [HASH_W-1:0] s;
    s = p.red[HASH_W-1:0] * HASH_W'(3) + p.green[HASH_W-1:0] * HASH_W'(5)
      + p.blue[HASH_W-1:0] * HASH_W'(7) + p.alpha[HASH_W-1:0] * HASH_W'(11);
    return s;
  endfunction

  function automatic logic [2:0] chunk_len(kind_t k);
    logic [2:0] n;
    unique case (k)
      KIND_INDEX: n = 3'd1;
      KIND_DIFF:  n = 3'd1;
      KIND_LUMA:  n = 3'd2;
      KIND_RGB:   n = 3'd4;
      KIND_RGBA:  n = 3'd5;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/qoi_enc_ram.sv =====
module qoi_enc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/qoi_enc_front.sv =====
module qoi_enc_front
  import qoi_enc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        q_full,
  output logic        q_push,
  output chunk_cmd_t  q_cmd
);

  // stage 1 holds the pixel while its index entry comes out of the ram
  logic              s1_valid;
  pixel_t            s1_px;
  logic              s1_last;
  logic [HASH_W-1:0] s1_hash;
  logic              fwd_valid;
  pixel_t            fwd_px;
  pixel_t            prev_px;
  logic [5:0]        run_len;
  logic [INDEX_DEPTH-1:0] idx_valid;

  pixel_t            in_px;
  logic [HASH_W-1:0] in_hash;
  logic              accept;
  logic              s1_fire;
  logic [PIXEL_W-1:0] ram_rd_data;
  logic              wr_en;
  pixel_t            index_entry;
  logic              same;
  logic              hit;
  logic [5:0]        run_inc;
  logic [5:0]        run_len_next;
  pixel_t            prev_next;
  logic [7:0]        du_r, du_g, du_b;
  logic [8:0]        vgr, vgb;
  logic              diff_ok, luma_ok;
  logic [7:0]        br, bg, bb, lg;
  logic [8:0]        lr, lb;

  assign in_px    = pixel_t'(s_axis_tdata);
  assign in_hash  = color_hash(in_px);
  assign s1_fire  = s1_valid && !q_full;
  assign s_axis_tready = !s1_valid || !q_full;
  assign accept   = s_axis_tvalid && s_axis_tready;

  qoi_enc_ram #(
    .WIDTH (PIXEL_W),
    .DEPTH (INDEX_DEPTH)
  ) u_index (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_hash),
    .wr_data (s1_px),
    .rd_en   (accept),
    .rd_addr (in_hash),
    .rd_data (ram_rd_data)
  );

  // entry never written since reset or image end reads as zero
  always_comb begin
    if (!idx_valid[s1_hash]) begin
      index_entry = '0;
    end else if (fwd_valid) begin
      index_entry = fwd_px;
    end else begin
      index_entry = pixel_t'(ram_rd_data);
    end
  end

  assign same    = (s1_px == prev_px);
  assign hit     = (index_entry == s1_px);
  assign wr_en   = s1_fire && !same && !hit;
  assign run_inc = run_len + 6'd1;

  // wrapped channel differences
  assign du_r = s1_px.red   - prev_px.red;
  assign du_g = s1_px.green - prev_px.green;
  assign du_b = s1_px.blue  - prev_px.blue;
  assign vgr  = {du_r[7], du_r} - {du_g[7], du_g};
  assign vgb  = {du_b[7], du_b} - {du_g[7], du_g};

  assign diff_ok = ($signed(du_r) >= -8'sd2) && ($signed(du_r) <= 8'sd1)
                && ($signed(du_g) >= -8'sd2) && ($signed(du_g) <= 8'sd1)
                && ($signed(du_b) >= -8'sd2) && ($signed(du_b) <= 8'sd1);
  assign luma_ok = ($signed(du_g) >= -8'sd32) && ($signed(du_g) <= 8'sd31)
                && ($signed(vgr) >= -9'sd8) && ($signed(vgr) <= 9'sd7)
                && ($signed(vgb) >= -9'sd8) && ($signed(vgb) <= 9'sd7);

  assign br = du_r + 8'd2;
  assign bg = du_g + 8'd2;
  assign bb = du_b + 8'd2;
  assign lg = du_g + 8'd32;
  assign lr = vgr + 9'd8;
  assign lb = vgb + 9'd8;

  always_comb begin
    q_cmd        = '0;
    q_cmd.px     = s1_px;
    q_cmd.last   = s1_last;
    q_cmd.kind   = KIND_NONE;
    q_push       = 1'b0;
    run_len_next = 6'd0;
    prev_next    = prev_px;
    if (same) begin
      q_cmd.has_run = 1'b1;
      q_cmd.run_m1  = run_len;
      if (run_inc == RUN_MAX || s1_last) begin
        q_push = s1_fire;
      end else begin
        run_len_next = run_inc;
      end
    end else begin
      q_push        = s1_fire;
      q_cmd.has_run = (run_len != 6'd0);
      q_cmd.run_m1  = run_len - 6'd1;
      prev_next     = s1_px;
      priority if (hit) begin
        q_cmd.kind = KIND_INDEX;
        q_cmd.op0  = OP_INDEX | {2'b00, s1_hash};
      end else if (s1_px.alpha != prev_px.alpha) begin
        q_cmd.kind = KIND_RGBA;
      end else if (diff_ok) begin
        q_cmd.kind = KIND_DIFF;
        q_cmd.op0  = OP_DIFF | {2'b00, br[1:0], bg[1:0], bb[1:0]};
      end else if (luma_ok) begin
        q_cmd.kind = KIND_LUMA;
        q_cmd.op0  = OP_LUMA | {2'b00, lg[5:0]};
        q_cmd.op1  = {lr[3:0], lb[3:0]};
      end else begin
        q_cmd.kind = KIND_RGB;
      end
    end
    if (s1_last) begin
      run_len_next = 6'd0;
      prev_next    = PREV_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      prev_px   <= PREV_RESET;
      run_len   <= 6'd0;
      idx_valid <= '0;
    end else begin
      if (accept) begin
        s1_valid  <= 1'b1;
        // ram returns old data when written at the address being read
        fwd_valid <= wr_en && (s1_hash == in_hash);
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        run_len <= run_len_next;
        prev_px <= prev_next;
        if (s1_last) begin
          idx_valid <= '0;
        end else if (wr_en) begin
          idx_valid[s1_hash] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px   <= in_px;
      s1_last <= s_axis_tlast;
      s1_hash <= in_hash;
      fwd_px  <= s1_px;
    end
  end

  a_run_below_max: assert property (@(posedge clk) disable iff (rst)
    run_len < RUN_MAX) else $error("run counter reached flush length");

  a_image_reset: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |=> run_len == 6'd0 && prev_px == PREV_RESET && idx_valid == '0)
    else $error("state not cleared after last pixel");

  a_last_emits: assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_last |-> q_push)
    else $error("last pixel produced no chunk");

endmodule

// ===== rtl/qoi_enc_queue.sv =====
module qoi_enc_queue
  import qoi_enc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  chunk_cmd_t push_cmd,
  output logic       full,
  input  logic       pop,
  output chunk_cmd_t head,
  output logic       head_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  chunk_cmd_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && !head_valid))
    else $error("queue overflow or underflow");

endmodule

// ===== rtl/qoi_enc_back.sv =====
module qoi_enc_back
  import qoi_enc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  chunk_cmd_t head,
  input  logic       head_valid,
  output logic       pop,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic       m_axis_tuser,
  output logic       m_axis_tlast
);

  logic [2:0] pos;
  logic [2:0] n_bytes;
  logic [2:0] q;
  logic       last_byte;
  logic       load;
  logic [7:0] byte_sel;

  assign n_bytes   = {2'b00, head.has_run} + chunk_len(head.kind);
  assign q         = pos - {2'b00, head.has_run};
  assign last_byte = (pos == n_bytes - 3'd1);
  assign load      = head_valid && (!m_axis_tvalid || m_axis_tready);
  assign pop       = load && last_byte;

  // byte at pos: the run byte if any, else the chunk byte at position q after the run byte
  always_comb begin
    if (head.has_run && pos == 3'd0) begin
      byte_sel = OP_RUN | {2'b00, head.run_m1};
    end else begin
      unique case (head.kind)
        KIND_INDEX, KIND_DIFF: byte_sel = head.op0;
        KIND_LUMA: byte_sel = (q == 3'd0) ? head.op0 : head.op1;
        KIND_RGB, KIND_RGBA: begin
          unique case (q)
            3'd0:    byte_sel = (head.kind == KIND_RGB) ? OP_RGB : OP_RGBA;
            3'd1:    byte_sel = head.px.red;
            3'd2:    byte_sel = head.px.green;
            3'd3:    byte_sel = head.px.blue;
            default: byte_sel = head.px.alpha;
          endcase
        end
        default: byte_sel = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      pos           <= 3'd0;
    end else begin
      if (load) begin
        m_axis_tvalid <= 1'b1;
        pos           <= last_byte ? 3'd0 : pos + 3'd1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_axis_tdata <= byte_sel;
      m_axis_tuser <= last_byte;
      m_axis_tlast <= last_byte && head.last;
    end
  end

  a_pos_in_chunk: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> pos < n_bytes)
    else $error("byte position past end of chunk");

  a_end_is_item_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("image end not on last byte of a pixel");

endmodule

// ===== rtl/qoi_image_encoder_top.sv =====
// qoi chunk-stream encoder, one rgba pixel per input request
// input stream: s_axis_tdata = {alpha, blue, green, red} (red in bits 7:0),
//   s_axis_tlast marks the final pixel of an image
// output stream: one chunk byte per request on m_axis_tdata, m_axis_tuser
//   flags the final byte caused by a pixel, m_axis_tlast the final byte of
//   the image; header and end padding are not produced
// front: a pixel register that reads the 64-entry colour index ram and
//   classifies the pixel (run, index, diff, luma, rgb, rgba) in the next cycle
// queue: QUEUE_DEPTH classified pixels between front and back
// back: serializes each chunk into bytes into the output register
// path: a pixel passes the stage-1 register and the queue into the output register
// throughput: one pixel per cycle while each pixel yields at most one byte and
//   the receiver does not stall; a pixel with more bytes (up to 6, an rgba
//   chunk after a run flush) slows the input, as the output port is one byte wide
// reset: index entries marked empty at once (valid flops, no clearing pass),
//   previous pixel to opaque black, run to zero; the same happens after the
//   last pixel of each image
// receiver stall: the output register holds, the queue fills, then
//   s_axis_tready drops until space frees up
module qoi_image_encoder_top
  import qoi_enc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // red, green, blue, alpha
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // code_byte
  output logic        m_axis_tuser,  // last_of_item
  output logic        m_axis_tlast
);

  // classified pixels travel front to back through the queue
  chunk_cmd_t q_cmd;
  chunk_cmd_t head;
  logic       q_push;
  logic       q_full;
  logic       head_valid;
  logic       pop;

  qoi_enc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  qoi_enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  // byte serializer with the output register
  qoi_enc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== verif/tb_qoi_image_encoder_top.sv =====
`timescale 1ns / 100ps

module tb_qoi_image_encoder_top;
  import qoi_enc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PIXELS = 450;

  // one byte of the chunk stream as it should leave the block
  typedef struct {
    logic [7:0] code;
    logic       item_end;
    logic       image_end;
  } chunk_byte_t;

  // predicts the chunk bytes of each accepted pixel and checks the output against them
  class chunk_stream_checker;
    pixel_t      palette [INDEX_DEPTH];
    pixel_t      prev;
    int          run_len;
    chunk_byte_t pending_bytes [$];
    int          errors;
    int          checked;
    int          n_run, n_index, n_diff, n_luma, n_rgb, n_rgba;

    function new();
      clear_image();
    endfunction

    // state at reset and after the last pixel of each image
    function void clear_image();
      foreach (palette[i]) palette[i] = '0;
      prev    = PREV_RESET;
      run_len = 0;
    endfunction

    // channel difference wrapped into -128..127
    static function int wrap8(logic [7:0] now, logic [7:0] was);
      logic [7:0] d;
      d = now - was;
      return (d >= 8'd128) ? int'(d) - 256 : int'(d);
    endfunction

    function void note_pixel(pixel_t px, bit last);
      logic [7:0] bytes [$];
      int         slot;
      int         vr, vg, vb, dr, db;
      if (px == prev) begin
        run_len++;
        if (run_len == RUN_MAX || last) begin
          bytes.push_back(OP_RUN | 8'(run_len - 1));
          run_len = 0;
          n_run++;
        end
      end else begin
        // a pending run always goes out ahead of the new chunk
        if (run_len > 0) begin
          bytes.push_back(OP_RUN | 8'(run_len - 1));
          run_len = 0;
          n_run++;
        end
        slot = (3 * px.red + 5 * px.green + 7 * px.blue + 11 * px.alpha) % INDEX_DEPTH;
        if (palette[slot] == px) begin
          bytes.push_back(OP_INDEX | 8'(slot));
          n_index++;
        end else begin
          palette[slot] = px;
          if (px.alpha == prev.alpha) begin
            vr = wrap8(px.red, prev.red);
            vg = wrap8(px.green, prev.green);
            vb = wrap8(px.blue, prev.blue);
            dr = vr - vg;
            db = vb - vg;
            if (vr >= -2 && vr <= 1 && vg >= -2 && vg <= 1 && vb >= -2 && vb <= 1) begin
              bytes.push_back(OP_DIFF | 8'(((vr + 2) << 4) | ((vg + 2) << 2) | (vb + 2)));
              n_diff++;
            end else if (dr >= -8 && dr <= 7 && vg >= -32 && vg <= 31 &&
                         db >= -8 && db <= 7) begin
              bytes.push_back(OP_LUMA | 8'(vg + 32));
              bytes.push_back(8'(((dr + 8) << 4) | (db + 8)));
              n_luma++;
            end else begin
              bytes.push_back(OP_RGB);
              bytes.push_back(px.red);
              bytes.push_back(px.green);
              bytes.push_back(px.blue);
              n_rgb++;
            end
          end else begin
            bytes.push_back(OP_RGBA);
            bytes.push_back(px.red);
            bytes.push_back(px.green);
            bytes.push_back(px.blue);
            bytes.push_back(px.alpha);
            n_rgba++;
          end
        end
        prev = px;
      end
      foreach (bytes[i])
        pending_bytes.push_back('{bytes[i], i == bytes.size() - 1,
                                  last && (i == bytes.size() - 1)});
      if (last) clear_image();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("mismatch: %s", msg);
    endtask

    task check_byte(logic [7:0] code, logic item_end, logic image_end);
      chunk_byte_t want;
      if (pending_bytes.size() == 0) begin
        report($sformatf("byte %02h arrived with nothing expected", code));
        return;
      end
      want = pending_bytes.pop_front();
      checked++;
      if (code !== want.code)
        report($sformatf("byte %0d: code %02h, expected %02h", checked, code, want.code));
      if (item_end !== want.item_end)
        report($sformatf("byte %0d: pixel end flag %b, expected %b", checked, item_end,
                         want.item_end));
      if (image_end !== want.image_end)
        report($sformatf("byte %0d: image end flag %b, expected %b", checked, image_end,
                         want.image_end));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // red, green, blue, alpha
  logic        s_axis_tlast;   // last pixel of the image
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // code byte
  logic        m_axis_tuser;   // last byte caused by the pixel
  logic        m_axis_tlast;   // last byte of the image

  chunk_stream_checker chunks;
  int                  cycle_count;
  int                  pixels_sent;
  int                  images_sent;
  int                  tx_mode;
  int                  rx_mode;
  pixel_t              recent [$];

  qoi_image_encoder_top uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // gap before a request: mode 0 never waits, mode 1 waits a random gap, possibly none, mode 2 waits now and then
  function automatic int draw_wait(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 16);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  function automatic pixel_t rgba(int r, int g, int b, int a);
    pixel_t p;
    p.red   = 8'(r);
    p.green = 8'(g);
    p.blue  = 8'(b);
    p.alpha = 8'(a);
    return p;
  endfunction

  // next pixel, biased toward the chunk kinds so that each one shows up often
  function automatic pixel_t next_pixel(pixel_t from);
    pixel_t p;
    int     roll;
    int     dg;
    roll = $urandom_range(0, 99);
    p    = from;
    if (roll < 25) begin
      p = from;
    end else if (roll < 42) begin
      p.red   = from.red + 8'($urandom_range(0, 3)) - 8'd2;
      p.green = from.green + 8'($urandom_range(0, 3)) - 8'd2;
      p.blue  = from.blue + 8'($urandom_range(0, 3)) - 8'd2;
    end else if (roll < 60) begin
      dg      = int'($urandom_range(0, 63)) - 32;
      p.green = from.green + 8'(dg);
      p.red   = from.red + 8'(dg + int'($urandom_range(0, 15)) - 8);
      p.blue  = from.blue + 8'(dg + int'($urandom_range(0, 15)) - 8);
    end else if (roll < 75 && recent.size() > 0) begin
      p = recent[$urandom_range(0, recent.size() - 1)];
    end else if (roll < 90) begin
      p.red   = 8'($urandom);
      p.green = 8'($urandom);
      p.blue  = 8'($urandom);
    end else begin
      p = pixel_t'($urandom);
      if ($urandom_range(0, 3) == 0) p.alpha = ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
    end
    return p;
  endfunction

  task automatic send_pixel(pixel_t p, bit last);
    int gap;
    gap = draw_wait(tx_mode);
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    chunks.note_pixel(p, last);
    pixels_sent++;
    if (last) images_sent++;
    recent.push_back(p);
    if (recent.size() > 16) void'(recent.pop_front());
  endtask

  // hold the input off until every predicted byte has come out
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (chunks.pending_bytes.size() > 0) @(posedge clk);
  endtask

  // output side: random stall before each byte
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait(rx_mode);
      repeat (stall) begin
        @(negedge clk);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk);
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // every accepted byte is compared with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      chunks.check_byte(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected", cycle_count,
               chunks.pending_bytes.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    pixel_t px;
    int     img_len;
    int     run_left;
    int     run_at;
    int     random_sent;
    bit     long_img;

    chunks        = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    tx_mode       = 0;
    rx_mode       = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed image: every chunk kind and the field extremes
    send_pixel(rgba(0, 0, 0, 0), 0);          // hits the zeroed index entry
    send_pixel(rgba(0, 0, 0, 0), 0);          // run grows, no byte
    send_pixel(rgba(0, 0, 0, 0), 0);
    send_pixel(rgba(1, 0, 255, 0), 0);        // run flush then diff
    send_pixel(rgba(255, 255, 255, 255), 0);  // alpha change
    send_pixel(rgba(254, 255, 0, 255), 0);    // small diff, wrapping
    send_pixel(rgba(252, 0, 255, 255), 0);    // diff at both ends of its range
    send_pixel(rgba(212, 224, 230, 255), 0);  // luma, lowest green and red offsets, highest blue
    send_pixel(rgba(250, 255, 253, 255), 0);  // luma, highest green and red offsets, lowest blue
    send_pixel(rgba(26, 31, 29, 255), 0);     // green just out of luma range
    send_pixel(rgba(0, 0, 0, 0), 0);          // index hit across an alpha change
    send_pixel(rgba(254, 255, 0, 255), 0);
    send_pixel(rgba(254, 255, 0, 255), 0);
    send_pixel(rgba(254, 255, 0, 255), 0);
    send_pixel(rgba(7, 7, 7, 7), 1);          // run flush plus rgba: six bytes
    // single pixel equal to the reset pixel: run of one flushed at image end
    send_pixel(rgba(0, 0, 0, 255), 1);
    // last pixel extends a run
    send_pixel(rgba(9, 9, 9, 9), 0);
    send_pixel(rgba(9, 9, 9, 9), 1);
    // index cleared after the image: no stale hit
    send_pixel(rgba(7, 7, 7, 7), 0);
    send_pixel(rgba(9, 9, 9, 9), 0);
    send_pixel(rgba(0, 0, 0, 0), 1);
    drain_results();

    // random images with shifting idle patterns on both sides
    random_sent = 0;
    px          = PREV_RESET;
    while (random_sent < RANDOM_PIXELS) begin
      tx_mode  = $urandom_range(0, 2);
      rx_mode  = $urandom_range(0, 2);
      long_img = ($urandom_range(0, 9) == 0);
      if (long_img) img_len = $urandom_range(70, 110);
      else if ($urandom_range(0, 3) == 0) img_len = $urandom_range(1, 3);
      else img_len = $urandom_range(4, 40);
      // the last image is cut to the remaining pixel budget
      if (img_len > RANDOM_PIXELS - random_sent) img_len = RANDOM_PIXELS - random_sent;
      // a long image carries one run around the flush limit
      run_at   = long_img ? $urandom_range(1, 8) : -1;
      run_left = 0;
      for (int i = 0; i < img_len; i++) begin
        if (i == run_at) run_left = $urandom_range(58, 66);
        if (run_left > 0) run_left--;
        else px = next_pixel(px);
        send_pixel(px, i == img_len - 1);
        random_sent++;
      end
      if (random_sent > RANDOM_PIXELS / 2 && random_sent - img_len <= RANDOM_PIXELS / 2)
        drain_results();
    end

    drain_results();
    repeat (32) @(posedge clk);
    $display("%0d pixels in %0d images, %0d chunk bytes checked", pixels_sent,
             images_sent, chunks.checked);
    $display("chunks: run %0d index %0d diff %0d luma %0d rgb %0d rgba %0d",
             chunks.n_run, chunks.n_index, chunks.n_diff, chunks.n_luma, chunks.n_rgb,
             chunks.n_rgba);
    if (chunks.errors == 0 && chunks.pending_bytes.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/qoi_enc_pkg.sv
rtl/qoi_enc_ram.sv
rtl/qoi_enc_front.sv
rtl/qoi_enc_queue.sv
rtl/qoi_enc_back.sv
rtl/qoi_image_encoder_top.sv
verif/tb_qoi_image_encoder_top.sv
